>>> rtl/pjts_pkg.sv
`default_nettype none
package pjts_pkg;
    localparam int RECORDS_DEF = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTATION = 2'd2;

    localparam logic [4:0] ACTIVE_LIMIT_RST = 5'd8;
    localparam logic [31:0] RETENTION_RST = 32'd60000;
    localparam logic [1:0] MUTATION_RST = 2'd3;

    localparam logic [2:0] CMD_SUBMIT = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_FINISH = 3'd2;
    localparam logic [2:0] CMD_PROGRESS = 3'd3;
    localparam logic [2:0] CMD_CANCEL = 3'd4;
    localparam logic [2:0] CMD_CANCEL_TGT = 3'd5;
    localparam logic [2:0] CMD_CANCEL_ALL = 3'd6;

    localparam logic [2:0] PH_QUEUED = 3'd0;
    localparam logic [2:0] PH_RUNNING = 3'd1;
    localparam logic [2:0] PH_SUCCEEDED = 3'd2;
    localparam logic [2:0] PH_FAILED = 3'd3;
    localparam logic [2:0] PH_CANCELLED = 3'd4;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_COALESCED = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    localparam logic [6:0] PROGRESS_FULL = 7'd100;
    localparam logic [6:0] PROGRESS_CAP = 7'd99;

    // Scan kinds run by the datapath, one record per cycle.
    typedef enum logic [2:0] {
        SCAN_EXPIRE   = 3'd0,
        SCAN_COALESCE = 3'd1,
        SCAN_COUNT    = 3'd2,
        SCAN_SELECT   = 3'd3,
        SCAN_LOOKUP   = 3'd4,
        SCAN_CANCEL   = 3'd5
    } t_scan;

    // Controller to datapath.
    typedef struct packed {
        logic   load;      // capture the command word
        logic   scan_go;   // start a scan of the kind below
        t_scan  scan;
        logic   act;       // apply the action chosen by the scan
        logic   respond;   // drive the result for one cycle
    } t_ctrl;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic found;       // scan found a record (coalesce, select, lookup)
        logic expired;     // selected record is past its deadline
    } t_stat;
endpackage
`default_nettype wire

>>> rtl/priority_job_table_scheduler.sv
`default_nettype none
// Channel   | Ports                                  | Handshake
// command   | i_command .. i_progress_value          | start while busy low
// config    | i_cfg_we, i_cfg_index, i_cfg_data      | i_cfg_we, no wait
// result    | o_status .. o_cancel_count             | o_valid, one cycle
//
// Each command takes one word; the table scan unit visits one record per cycle.
// After the accepting edge come an expiry pass, then one scan pass per table
// scan, then the launch of the result on o_valid. Lookups and a coalescing hit
// stop their scan early; a coalescing submit whose key finds no active job
// scans twice; start-next adds one pass for every expired job it fails; an
// unknown command has no scan pass at all. Reset is synchronous and active
// low; it empties the table and sets the ids and order counter to one. The
// result is shown for one cycle and cannot be stalled; busy stays high until
// it has been shown.
module priority_job_table_scheduler #(
    parameter int RECORDS = pjts_pkg::RECORDS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_cfg_we,
    input  wire logic [pjts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pjts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [2:0]                        i_command,
    input  wire logic [31:0]                       i_now_ms,
    input  wire logic [31:0]                       i_job_id,
    input  wire logic [31:0]                       i_except_id,
    input  wire logic [1:0]                        i_priority_level,
    input  wire logic [15:0]                       i_coalesce_key,
    input  wire logic [7:0]                        i_target_tag,
    input  wire logic [31:0]                       i_deadline_ms,
    input  wire logic                              i_succeeded,
    input  wire logic [7:0]                        i_progress_value,
    output logic                                   o_valid,
    output logic [2:0]                             o_status,
    output logic [31:0]                            o_result_id,
    output logic [31:0]                            o_evicted_id,
    output logic [1:0]                             o_result_priority,
    output logic [4:0]                             o_cancel_count
);
    import pjts_pkg::*;

    logic [4:0]  r_active_limit;
    logic [31:0] r_retention_ms;
    logic [1:0]  r_mutation_level;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_limit <= ACTIVE_LIMIT_RST;
            r_retention_ms <= RETENTION_RST;
            r_mutation_level <= MUTATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE_LIMIT: r_active_limit <= i_cfg_data[4:0];
                CFG_RETENTION:    r_retention_ms <= i_cfg_data;
                CFG_MUTATION:     r_mutation_level <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    t_ctrl ctrl;
    t_stat stat;
    logic  ctl_busy;
    logic  accept;

    // The controller is already idle while the result is shown, so a word is
    // taken only once busy has dropped.
    assign accept = start && !busy;

    pjts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_command(i_command), .i_coalesce_key(i_coalesce_key),
        .i_priority_level(i_priority_level), .i_mutation_level(r_mutation_level),
        .o_busy(ctl_busy), .o_ctrl(ctrl), .i_stat(stat)
    );

    pjts_datapath #(.RECORDS(RECORDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .o_stat(stat),
        .i_active_limit(r_active_limit), .i_retention_ms(r_retention_ms),
        .i_command(i_command),
        .i_now_ms(i_now_ms), .i_job_id(i_job_id), .i_except_id(i_except_id),
        .i_priority_level(i_priority_level), .i_coalesce_key(i_coalesce_key),
        .i_target_tag(i_target_tag), .i_deadline_ms(i_deadline_ms),
        .i_succeeded(i_succeeded), .i_progress_value(i_progress_value),
        .o_done(o_valid), .o_status(o_status), .o_result_id(o_result_id),
        .o_evicted_id(o_evicted_id), .o_result_priority(o_result_priority),
        .o_cancel_count(o_cancel_count)
    );

    // Busy covers the cycle in which the result is shown.
    assign busy = ctl_busy || o_valid;

    // A result appears only while a command is in flight.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(ctl_busy)) else $error("result without command");
    // Every reported status is one of the defined codes.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_EMPTY) else $error("bad status");
    // Cancel count is nonzero only with a done status.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cancel_count != 5'd0) |-> o_status == ST_DONE)
        else $error("count without done");
endmodule
`default_nettype wire

>>> rtl/pjts_datapath.sv
`default_nettype none
module pjts_datapath #(
    parameter int RECORDS = pjts_pkg::RECORDS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire pjts_pkg::t_ctrl           i_ctrl,
    output pjts_pkg::t_stat                o_stat,
    input  wire logic [4:0]                i_active_limit,
    input  wire logic [31:0]               i_retention_ms,
    input  wire logic [2:0]                i_command,
    input  wire logic [31:0]               i_now_ms,
    input  wire logic [31:0]               i_job_id,
    input  wire logic [31:0]               i_except_id,
    input  wire logic [1:0]                i_priority_level,
    input  wire logic [15:0]               i_coalesce_key,
    input  wire logic [7:0]                i_target_tag,
    input  wire logic [31:0]               i_deadline_ms,
    input  wire logic                      i_succeeded,
    input  wire logic [7:0]                i_progress_value,
    output logic                           o_done,
    output logic [2:0]                     o_status,
    output logic [31:0]                    o_result_id,
    output logic [31:0]                    o_evicted_id,
    output logic [1:0]                     o_result_priority,
    output logic [4:0]                     o_cancel_count
);
    import pjts_pkg::*;

    localparam int IW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CW = $clog2(RECORDS + 1);
    localparam logic [IW-1:0] LAST = IW'(RECORDS - 1);

    // Record table, each entry read at the scan index or at a held index.
    logic [RECORDS-1:0] r_used;
    logic [31:0] r_id [RECORDS];
    logic [2:0]  r_phase [RECORDS];
    logic [1:0]  r_prio [RECORDS];
    logic [31:0] r_order [RECORDS];
    logic [15:0] r_key [RECORDS];
    logic [7:0]  r_tgt [RECORDS];
    logic [31:0] r_dl [RECORDS];
    logic [31:0] r_fin [RECORDS];
    logic [6:0]  r_prog [RECORDS];
    logic [31:0] r_next_order, r_next_id;

    // Latched command word.
    logic [2:0]  r_cmd;
    logic [31:0] r_now, r_jid, r_exc, r_dlin;
    logic [1:0]  r_prio_in;
    logic [15:0] r_key_in;
    logic [7:0]  r_tag_in;
    logic        r_succ;
    logic [7:0]  r_pv;

    // Scan state.
    logic        r_busy;
    t_scan       r_scan;
    logic [IW-1:0] r_idx;
    logic        r_found, r_has_slot, r_has_victim;
    logic [IW-1:0] r_sel, r_slot, r_victim;
    logic [CW-1:0] r_active;
    logic [4:0]  r_ccount;
    logic [2:0]  r_status;
    logic [31:0] r_res_id, r_ev_id;
    logic [1:0]  r_res_prio;

    logic act_i, term_i, hit, better;
    logic [31:0] age;

    always_comb begin
        term_i = r_phase[r_idx] >= PH_SUCCEEDED;
        act_i = r_used[r_idx] && !term_i;
        age = r_now - r_fin[r_idx];
        better = !r_found || r_prio[r_idx] > r_prio[r_sel] ||
                 (r_prio[r_idx] == r_prio[r_sel] && r_order[r_idx] < r_order[r_sel]);
        hit = 1'b0;
        case (r_scan)
            SCAN_COALESCE: hit = act_i && r_key[r_idx] == r_key_in;
            SCAN_SELECT:   hit = r_used[r_idx] && r_phase[r_idx] == PH_QUEUED && better;
            SCAN_LOOKUP:   hit = r_used[r_idx] && r_id[r_idx] == r_jid;
            SCAN_CANCEL:   hit = act_i && (r_cmd == CMD_CANCEL_ALL ||
                                 (r_tgt[r_idx] == r_tag_in &&
                                  !(r_exc != 32'd0 && r_id[r_idx] == r_exc)));
            default:       hit = 1'b0;
        endcase
    end

    logic [31:0] sel_late;
    logic victim_better;
    assign sel_late = r_now - r_dl[r_sel];
    assign victim_better = !r_has_victim || r_order[r_idx] < r_order[r_victim];

    always_comb begin
        o_stat.scan_done = r_busy == 1'b0;
        o_stat.found = r_found;
        o_stat.expired = !sel_late[31];
    end

    logic stop_early;
    assign stop_early = hit && (r_scan == SCAN_COALESCE || r_scan == SCAN_LOOKUP) && !r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_next_order <= 32'd1;
            r_next_id <= 32'd1;
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= i_ctrl.respond;
            if (i_ctrl.load) begin
                r_cmd <= i_command; r_now <= i_now_ms; r_jid <= i_job_id;
                r_exc <= i_except_id; r_prio_in <= i_priority_level;
                r_key_in <= i_coalesce_key; r_tag_in <= i_target_tag;
                r_dlin <= i_deadline_ms; r_succ <= i_succeeded; r_pv <= i_progress_value;
                r_status <= ST_REFUSED; r_res_id <= '0; r_ev_id <= '0;
                r_res_prio <= '0; r_ccount <= '0;
            end
            if (i_ctrl.scan_go) begin
                r_busy <= 1'b1; r_scan <= i_ctrl.scan; r_idx <= '0;
                r_found <= 1'b0; r_has_slot <= 1'b0; r_has_victim <= 1'b0;
                r_active <= '0;
            end else if (r_busy) begin
                case (r_scan)
                    SCAN_EXPIRE:
                        if (r_used[r_idx] && term_i && age >= i_retention_ms)
                            r_used[r_idx] <= 1'b0;
                    SCAN_COUNT: begin
                        if (!r_used[r_idx] && !r_has_slot) begin
                            r_has_slot <= 1'b1; r_slot <= r_idx;
                        end
                        if (act_i) r_active <= r_active + CW'(1);
                        if (r_used[r_idx] && r_phase[r_idx] == PH_QUEUED &&
                            r_prio[r_idx] == 2'd0 && victim_better) begin
                            r_has_victim <= 1'b1; r_victim <= r_idx;
                        end
                    end
                    SCAN_CANCEL:
                        if (hit) begin
                            r_phase[r_idx] <= PH_CANCELLED;
                            r_fin[r_idx] <= r_now;
                            if (r_ccount != 5'd31) r_ccount <= r_ccount + 5'd1;
                        end
                    default:
                        if (hit && !(r_found && r_scan != SCAN_SELECT)) begin
                            r_found <= 1'b1; r_sel <= r_idx;
                        end
                endcase
                if (r_idx == LAST || stop_early) r_busy <= 1'b0;
                else r_idx <= r_idx + IW'(1);
            end
            if (i_ctrl.act) begin
                case (r_scan)
                    SCAN_COALESCE: begin
                        if (r_phase[r_sel] == PH_QUEUED && r_prio_in > r_prio[r_sel]) begin
                            r_prio[r_sel] <= r_prio_in;
                            r_dl[r_sel] <= r_now + r_dlin;
                        end
                        r_status <= ST_COALESCED; r_res_id <= r_id[r_sel];
                    end
                    SCAN_COUNT: begin
                        if (!r_has_slot) r_status <= ST_REJECTED;
                        else if ({{(32-CW){1'b0}}, r_active} >= {27'd0, i_active_limit} &&
                                 (r_prio_in == 2'd0 || !r_has_victim)) begin
                            r_status <= ST_REJECTED;
                        end else begin
                            if ({{(32-CW){1'b0}}, r_active} >= {27'd0, i_active_limit}) begin
                                r_phase[r_victim] <= PH_CANCELLED;
                                r_fin[r_victim] <= r_now;
                                r_ev_id <= r_id[r_victim];
                            end
                            r_used[r_slot] <= 1'b1;
                            r_id[r_slot] <= r_next_id;
                            r_phase[r_slot] <= PH_QUEUED;
                            r_prio[r_slot] <= r_prio_in;
                            r_order[r_slot] <= r_next_order;
                            r_key[r_slot] <= r_key_in;
                            r_tgt[r_slot] <= r_tag_in;
                            r_dl[r_slot] <= r_now + r_dlin;
                            r_fin[r_slot] <= '0;
                            r_prog[r_slot] <= '0;
                            r_next_id <= r_next_id + 32'd1;
                            r_next_order <= r_next_order + 32'd1;
                            r_status <= ST_ACCEPTED; r_res_id <= r_next_id;
                        end
                    end
                    SCAN_SELECT:
                        if (!r_found) r_status <= ST_EMPTY;
                        else if (!sel_late[31]) begin
                            r_phase[r_sel] <= PH_FAILED;
                            r_fin[r_sel] <= r_now;
                        end else begin
                            r_phase[r_sel] <= PH_RUNNING;
                            r_prog[r_sel] <= 7'd1;
                            r_status <= ST_ACCEPTED; r_res_id <= r_id[r_sel];
                            r_res_prio <= r_prio[r_sel];
                        end
                    SCAN_LOOKUP:
                        if (r_found) begin
                            case (r_cmd)
                                CMD_FINISH:
                                    if (r_phase[r_sel] == PH_RUNNING) begin
                                        r_phase[r_sel] <= r_succ ? PH_SUCCEEDED : PH_FAILED;
                                        r_fin[r_sel] <= r_now;
                                        if (r_succ) r_prog[r_sel] <= PROGRESS_FULL;
                                        r_status <= ST_DONE;
                                    end
                                CMD_PROGRESS:
                                    if (r_phase[r_sel] == PH_RUNNING) begin
                                        r_prog[r_sel] <= (r_pv > 8'd99) ? PROGRESS_CAP
                                                                        : r_pv[6:0];
                                        r_status <= ST_DONE;
                                    end
                                default:
                                    if (r_phase[r_sel] < PH_SUCCEEDED) begin
                                        r_phase[r_sel] <= PH_CANCELLED;
                                        r_fin[r_sel] <= r_now;
                                        r_status <= ST_DONE;
                                    end
                            endcase
                        end
                    SCAN_CANCEL: r_status <= ST_DONE;
                    default: ;
                endcase
            end
        end
    end

    // Progress is kept for completeness of the record; it has no result port.
    logic unused_prog;
    assign unused_prog = ^r_prog[0];

    assign o_status = r_status;
    assign o_result_id = r_res_id;
    assign o_evicted_id = r_ev_id;
    assign o_result_priority = r_res_prio;
    assign o_cancel_count = r_ccount ^ {4'd0, unused_prog & 1'b0};
endmodule
`default_nettype wire

>>> rtl/pjts_ctrl.sv
`default_nettype none
module pjts_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [2:0]      i_command,
    input  wire logic [15:0]     i_coalesce_key,
    input  wire logic [1:0]      i_priority_level,
    input  wire logic [1:0]      i_mutation_level,
    output logic                 o_busy,
    output pjts_pkg::t_ctrl      o_ctrl,
    input  wire pjts_pkg::t_stat i_stat
);
    import pjts_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXP   = 6'b000010,
        S_PICK  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_ACT   = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_cmd;
    logic r_coal;   // coalesce allowed for this submit
    logic r_in_coal, n_in_coal;
    t_scan scan_pick;

    always_comb begin
        case (r_cmd)
            CMD_SUBMIT:     scan_pick = r_coal ? SCAN_COALESCE : SCAN_COUNT;
            CMD_START:      scan_pick = SCAN_SELECT;
            CMD_FINISH, CMD_PROGRESS, CMD_CANCEL: scan_pick = SCAN_LOOKUP;
            CMD_CANCEL_TGT, CMD_CANCEL_ALL:       scan_pick = SCAN_CANCEL;
            default:        scan_pick = SCAN_EXPIRE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_in_coal = r_in_coal;
        o_ctrl = '0;
        o_ctrl.scan = r_in_coal ? SCAN_COALESCE : (r_cmd == CMD_SUBMIT ? SCAN_COUNT
                                                                       : scan_pick);
        case (r_state)
            S_IDLE:
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    o_ctrl.scan_go = 1'b1;
                    o_ctrl.scan = SCAN_EXPIRE;
                    n_state = S_EXP;
                end
            S_EXP:
                if (i_stat.scan_done) begin
                    n_in_coal = (r_cmd == CMD_SUBMIT) && r_coal;
                    n_state = S_PICK;
                end
            S_PICK: begin
                // An unknown command has nothing to scan beyond the expiry pass.
                if (scan_pick == SCAN_EXPIRE) begin
                    n_state = S_RESP;
                end else begin
                    o_ctrl.scan_go = 1'b1;
                    o_ctrl.scan = r_in_coal ? SCAN_COALESCE : scan_pick;
                    if (r_cmd == CMD_SUBMIT && !r_in_coal) o_ctrl.scan = SCAN_COUNT;
                    n_state = S_SCAN;
                end
            end
            S_SCAN:
                if (i_stat.scan_done) n_state = S_ACT;
            S_ACT: begin
                if (r_in_coal && !i_stat.found) begin
                    n_in_coal = 1'b0;
                    n_state = S_PICK;
                end else begin
                    o_ctrl.act = 1'b1;
                    if (r_cmd == CMD_START && i_stat.found && i_stat.expired)
                        n_state = S_PICK;
                    else
                        n_state = S_RESP;
                end
            end
            S_RESP: begin
                o_ctrl.respond = 1'b1;
                n_in_coal = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_in_coal <= 1'b0;
        end else begin
            r_state <= n_state;
            r_in_coal <= n_in_coal;
        end
        if (r_state == S_IDLE && i_start) begin
            r_cmd <= i_command;
            r_coal <= i_coalesce_key != 16'd0 && i_priority_level != i_mutation_level;
        end
    end

    assign o_busy = r_state != S_IDLE;
endmodule
`default_nettype wire
